/* src/cpu6502_effective_address_top_macros.svh */
// assertion macros shared by the effective address block
`ifndef CPU6502_EFFECTIVE_ADDRESS_TOP_MACROS_SVH
`define CPU6502_EFFECTIVE_ADDRESS_TOP_MACROS_SVH
`ifndef SYNTHESIS
// property checked at every rising edge outside reset
`define CEA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen outside reset
`define CEA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CEA_ASSERT(lbl, clk, rst_n, prop, msg)
`define CEA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* src/cea_pkg.sv */
`default_nettype none
package cea_pkg;

	localparam int ADDR_W    = 16;
	localparam int DATA_W    = 8;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	// item kinds
	localparam logic KIND_STORE   = 1'b0;
	localparam logic KIND_RESOLVE = 1'b1;

	// addressing modes
	localparam logic [3:0] MODE_IMP  = 4'd0;
	localparam logic [3:0] MODE_ACC  = 4'd1;
	localparam logic [3:0] MODE_IMM  = 4'd2;
	localparam logic [3:0] MODE_ZP   = 4'd3;
	localparam logic [3:0] MODE_ZPX  = 4'd4;
	localparam logic [3:0] MODE_ZPY  = 4'd5;
	localparam logic [3:0] MODE_ABS  = 4'd6;
	localparam logic [3:0] MODE_ABSX = 4'd7;
	localparam logic [3:0] MODE_ABSY = 4'd8;
	localparam logic [3:0] MODE_REL  = 4'd9;
	localparam logic [3:0] MODE_IND  = 4'd10;
	localparam logic [3:0] MODE_INDX = 4'd11;
	localparam logic [3:0] MODE_INDY = 4'd12;

	// operand sources
	localparam logic [1:0] SRC_NONE = 2'd0;
	localparam logic [1:0] SRC_ACC  = 2'd1;
	localparam logic [1:0] SRC_IMM  = 2'd2;
	localparam logic [1:0] SRC_MEM  = 2'd3;

	typedef struct packed {
		logic               kind;
		logic [3:0]         mode;
		logic [7:0]         operand_low;
		logic [7:0]         operand_high;
		logic [7:0]         index_x;
		logic [7:0]         index_y;
		logic [ADDR_W-1:0]  program_counter;
		logic [ADDR_W-1:0]  store_address;
		logic [DATA_W-1:0]  store_data;
	} item_t;

	typedef struct packed {
		logic [1:0]        operand_source;
		logic [ADDR_W-1:0] effective_address;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PTR_LO,
		S_PTR_HI
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic step_hi;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ptr_item;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

/* src/cea_ctrl.sv */
`default_nettype none
`include "cpu6502_effective_address_top_macros.svh"
module cea_ctrl (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic item_valid,
	output logic               item_ready,
	input  wire                cea_pkg::status_t status,
	output cea_pkg::cmd_t      cmd
);
	import cea_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   take_ok;

	assign take_ok = item_valid && (state_q == S_IDLE) && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take_ok && status.ptr_item) begin
					state_d = S_PTR_LO;
				end
			end
			S_PTR_LO: begin
				state_d = S_PTR_HI;
			end
			S_PTR_HI: begin
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		item_ready  = 1'b0;
		cmd.take    = 1'b0;
		cmd.step_hi = 1'b0;
		cmd.finish  = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = status.out_free;
				cmd.take   = take_ok;
			end
			S_PTR_LO: begin
				cmd.step_hi = 1'b1;
			end
			S_PTR_HI: begin
				cmd.finish = status.out_free;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	`CEA_ASSERT(a_ptr_enters_seq, clk, arst_n, (cmd.take && status.ptr_item) |=> (state_q == S_PTR_LO), "pointer transaction did not start the fetch")
	`CEA_ASSERT(a_lo_then_hi, clk, arst_n, (state_q == S_PTR_LO) |=> (state_q == S_PTR_HI), "low pointer byte not followed by high byte")
	`CEA_ASSERT(a_finish_to_idle, clk, arst_n, cmd.finish |=> (state_q == S_IDLE && !cmd.finish), "pointer fetch did not return to idle")
	`CEA_ASSERT_NEVER(a_take_during_fetch, clk, arst_n, cmd.take && (cmd.step_hi || cmd.finish), "transaction taken while pointer fetch busy")

endmodule
`default_nettype wire

/* src/cea_dp.sv */
`default_nettype none
module cea_dp (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                cea_pkg::item_t item,
	input  wire                cea_pkg::cmd_t cmd,
	output cea_pkg::status_t   status,
	output logic               result_valid,
	input  wire                logic result_ready,
	output cea_pkg::result_t   result
);
	import cea_pkg::*;

	logic [DATA_W-1:0] mem_q [MEM_DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic [ADDR_W-1:0] mem_addr;
	logic              mem_we;
	logic              mem_re;

	logic [ADDR_W-1:0] ptr_q;
	logic              zp_ptr_q;
	logic [7:0]        ofs_q;
	logic [7:0]        lo_q;

	logic              out_valid_q;
	result_t           out_q;

	logic              is_store;
	logic              is_ptr;
	logic [ADDR_W-1:0] word;
	logic [7:0]        zpx;
	logic [ADDR_W-1:0] first_addr;
	logic [ADDR_W-1:0] next_addr;
	result_t           direct;
	result_t           ptr_res;
	logic              load_out;

	assign word     = {item.operand_high, item.operand_low};
	assign zpx      = item.operand_low + item.index_x;
	assign is_store = (item.kind == KIND_STORE);
	assign is_ptr   = !is_store && (item.mode inside {MODE_IND, MODE_INDX, MODE_INDY});

	// first pointer byte address, zero page for the two indexed pointer modes
	always_comb begin
		case (item.mode)
			MODE_IND:  first_addr = word;
			MODE_INDX: first_addr = {8'h00, zpx};
			default:   first_addr = {8'h00, item.operand_low};
		endcase
	end

	assign next_addr = zp_ptr_q ? {8'h00, ptr_q[7:0] + 8'd1} : ptr_q + 16'd1;

	// single port: store write, or one pointer byte read
	assign mem_we   = cmd.take && is_store;
	assign mem_re   = (cmd.take && is_ptr) || cmd.step_hi;
	assign mem_addr = mem_we ? item.store_address : (cmd.step_hi ? next_addr : first_addr);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= item.store_data;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && is_ptr) begin
			ptr_q    <= first_addr;
			zp_ptr_q <= (item.mode != MODE_IND);
			ofs_q    <= (item.mode == MODE_INDY) ? item.index_y : 8'h00;
		end
		if (cmd.step_hi) begin
			lo_q <= rdata_q;
		end
	end

	// modes resolved without memory
	always_comb begin
		direct.operand_source    = SRC_NONE;
		direct.effective_address = '0;
		if (!is_store) begin
			case (item.mode)
				MODE_ACC: begin
					direct.operand_source = SRC_ACC;
				end
				MODE_IMM: begin
					direct.operand_source = SRC_IMM;
				end
				MODE_ZP: begin
					direct.operand_source    = SRC_MEM;
					direct.effective_address = {8'h00, item.operand_low};
				end
				MODE_ZPX: begin
					direct.operand_source    = SRC_MEM;
					direct.effective_address = {8'h00, zpx};
				end
				MODE_ZPY: begin
					direct.operand_source    = SRC_MEM;
					direct.effective_address = {8'h00, item.operand_low + item.index_y};
				end
				MODE_ABS: begin
					direct.operand_source    = SRC_MEM;
					direct.effective_address = word;
				end
				MODE_ABSX: begin
					direct.operand_source    = SRC_MEM;
					direct.effective_address = word + {8'h00, item.index_x};
				end
				MODE_ABSY: begin
					direct.operand_source    = SRC_MEM;
					direct.effective_address = word + {8'h00, item.index_y};
				end
				MODE_REL: begin
					direct.operand_source    = SRC_MEM;
					direct.effective_address = item.program_counter
						+ {{8{item.operand_low[7]}}, item.operand_low};
				end
				default: begin
					direct.operand_source = SRC_NONE;
				end
			endcase
		end
	end

	assign ptr_res.operand_source    = SRC_MEM;
	assign ptr_res.effective_address = {rdata_q, lo_q} + {8'h00, ofs_q};

	assign load_out = (cmd.take && !is_ptr) || cmd.finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= cmd.finish ? ptr_res : direct;
		end
	end

	assign status.ptr_item = is_ptr;
	assign status.out_free = !out_valid_q || result_ready;
	assign result_valid    = out_valid_q;
	assign result          = out_q;

endmodule
`default_nettype wire

/* src/cpu6502_effective_address_top.sv */
// store, direct and relative modes give their result in the cycle after acceptance
// pointer modes (ind, (zp,x), (zp),y) give theirs once the single memory port has read
// the two pointer bytes in turn and the result register is free; non-pointer items go
// at one per cycle while the result register is free; a pointer item blocks new items
// reset: arst_n clears the controller state and the result valid flag, no clearing pass;
// the 64k-byte memory holds nothing defined until it is written
`default_nettype none
module cpu6502_effective_address_top (
	input  wire                logic clk,
	input  wire                logic arst_n,
	// item channel
	input  wire                logic item_valid,
	output logic               item_ready,
	input  wire                cea_pkg::item_t item,
	// result channel
	output logic               result_valid,
	input  wire                logic result_ready,
	output cea_pkg::result_t   result
);
	import cea_pkg::*;

	// command and status between controller and datapath
	cmd_t    cmd;
	status_t status;

	// controller: idle, then two pointer byte fetch states for pointer modes
	cea_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// datapath: address arithmetic, the byte memory and the result register
	// the result register lets a new transaction in during the cycle its last result is taken
	cea_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire
